// ===== design/hierarchical_page_walk_with_eviction_assert.svh =====
// ----------------------------------------------------------------------------
// page walk assertion macros
// shorthand for clocked implication checks with synchronous reset disable
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_PAGE_WALK_WITH_EVICTION_ASSERT_SVH
`define HIERARCHICAL_PAGE_WALK_WITH_EVICTION_ASSERT_SVH

// same-cycle implication
`define HPWE_AST_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page walk check failed");

// next-cycle implication
`define HPWE_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page walk check failed");

`endif

// ===== design/hpwe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwe_pkg
// constants, types and helper functions of the page walk block
// ----------------------------------------------------------------------------
package hpwe_pkg;

  localparam int OFFSET_BITS  = 4;
  localparam int TABLE_LEVELS = 2;
  localparam int FRAME_COUNT  = 16;
  localparam int WORD_BITS    = 32;

  localparam int PAGE_WORDS = 1 << OFFSET_BITS;
  localparam int VA_BITS    = OFFSET_BITS * (TABLE_LEVELS + 1);
  localparam int PG_W       = OFFSET_BITS * TABLE_LEVELS;
  localparam int PAGE_COUNT = 1 << PG_W;
  localparam int FRM_W      = $clog2(FRAME_COUNT);
  localparam int FM_AW      = FRM_W + OFFSET_BITS;
  localparam int FM_DEPTH   = FRAME_COUNT * PAGE_WORDS;
  localparam int SW_AW      = VA_BITS;
  localparam int SW_DEPTH   = 1 << SW_AW;
  localparam int LVL_W      = (TABLE_LEVELS > 1) ? $clog2(TABLE_LEVELS) : 1;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [FRM_W-1:0]       frm_t;
  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [PG_W-1:0]        page_t;
  typedef logic [PG_W:0]          dist_t;
  typedef logic [LVL_W-1:0]       lvl_t;
  typedef logic [FM_AW-1:0]       fm_addr_t;

  // outcome of one table scan
  typedef struct packed {
    logic  have_zero;
    word_t zero_frame;
    frm_t  zero_parent;
    off_t  zero_slot;
    word_t top_frame;
    logic  have_victim;
    dist_t best_dist;
    word_t victim_frame;
    page_t victim_page;
    frm_t  victim_parent;
    off_t  victim_slot;
  } scan_res_t;

  // frame numbers wrap onto the frame memory
  function automatic fm_addr_t fm_addr(input word_t frame, input off_t off);
    return {frame[FRM_W-1:0], off};
  endfunction

  // min(P - |a-b|, |a-b|)
  function automatic dist_t cyc_dist(input page_t a, input page_t b);
    dist_t d;
    dist_t alt;
    d   = (a > b) ? dist_t'(a - b) : dist_t'(b - a);
    alt = dist_t'(PAGE_COUNT) - d;
    return (alt < d) ? alt : d;
  endfunction

endpackage

// ===== design/hpwe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwe_if
// request and response channels of the page walk block
// ----------------------------------------------------------------------------
interface hpwe_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [15:0]        virt_addr;
  logic signed [31:0] write_data;
  modport source (output valid, func, virt_addr, write_data, input ready);
  modport sink   (input valid, func, virt_addr, write_data, output ready);
endinterface

interface hpwe_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] read_data;
  modport source (output valid, ok, read_data, input ready);
  modport sink   (input valid, ok, read_data, output ready);
endinterface

// ===== design/hpwe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hpwe_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/hpwe_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwe_scan
// depth-first table scan: free table frame, highest frame, eviction victim
// ----------------------------------------------------------------------------
module hpwe_scan import hpwe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  word_t     entered,
  input  page_t     target,
  input  word_t     rdata,
  output fm_addr_t  raddr,
  output logic      done,
  output scan_res_t res
);
  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_RD   = 3'b010,
    SC_EV   = 3'b100
  } sc_state_t;

  sc_state_t            st;
  lvl_t                 d;
  word_t                frm_stk   [TABLE_LEVELS];
  logic [OFFSET_BITS:0] idx_stk   [TABLE_LEVELS];
  logic                 allz_stk  [TABLE_LEVELS];
  frm_t                 pfrm_stk  [TABLE_LEVELS];
  off_t                 pslot_stk [TABLE_LEVELS];

  word_t                cur_frm;
  logic [OFFSET_BITS:0] cur_idx;
  logic                 is_leaf;
  page_t                leaf_page;
  dist_t                cd;

  always_comb begin
    cur_frm = frm_stk[d];
    cur_idx = idx_stk[d];
    raddr   = fm_addr(cur_frm, cur_idx[OFFSET_BITS-1:0]);
    is_leaf = (d == lvl_t'(TABLE_LEVELS - 1));
    // page number from the slots taken on the way down
    leaf_page = '0;
    for (int k = 1; k < TABLE_LEVELS; k++) begin
      leaf_page[(TABLE_LEVELS-k)*OFFSET_BITS +: OFFSET_BITS] = pslot_stk[k];
    end
    leaf_page[OFFSET_BITS-1:0] = idx_stk[TABLE_LEVELS-1][OFFSET_BITS-1:0];
    cd = cyc_dist(target, leaf_page);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= SC_IDLE;
      done <= 1'b0;
      d    <= '0;
    end else begin
      done <= 1'b0;
      unique case (st)
        SC_IDLE: begin
          if (start) begin
            d           <= '0;
            frm_stk[0]  <= '0;
            idx_stk[0]  <= '0;
            allz_stk[0] <= 1'b1;
            res         <= '0;
            st          <= SC_RD;
          end
        end
        SC_RD: begin
          if (cur_idx == (OFFSET_BITS+1)'(PAGE_WORDS)) begin
            // frame finished: post-order free table check
            if (allz_stk[d] && cur_frm != entered && d != '0) begin
              res.have_zero   <= 1'b1;
              res.zero_frame  <= cur_frm;
              res.zero_parent <= pfrm_stk[d];
              res.zero_slot   <= pslot_stk[d];
            end
            if (d == '0) begin
              done <= 1'b1;
              st   <= SC_IDLE;
            end else begin
              d <= d - lvl_t'(1);
            end
          end else begin
            st <= SC_EV;
          end
        end
        SC_EV: begin
          st         <= SC_RD;
          idx_stk[d] <= cur_idx + (OFFSET_BITS+1)'(1);
          if (rdata != '0) begin
            allz_stk[d] <= 1'b0;
            if (rdata > res.top_frame) begin
              res.top_frame <= rdata;
            end
            if (is_leaf) begin
              if (rdata != entered && cd > res.best_dist) begin
                res.best_dist     <= cd;
                res.have_victim   <= 1'b1;
                res.victim_frame  <= rdata;
                res.victim_page   <= leaf_page;
                res.victim_parent <= cur_frm[FRM_W-1:0];
                res.victim_slot   <= cur_idx[OFFSET_BITS-1:0];
              end
            end else begin
              // descend into the child table
              frm_stk[d + lvl_t'(1)]   <= rdata;
              idx_stk[d + lvl_t'(1)]   <= '0;
              allz_stk[d + lvl_t'(1)]  <= 1'b1;
              pfrm_stk[d + lvl_t'(1)]  <= cur_frm[FRM_W-1:0];
              pslot_stk[d + lvl_t'(1)] <= cur_idx[OFFSET_BITS-1:0];
              d                        <= d + lvl_t'(1);
            end
          end
        end
        default: st <= SC_IDLE;
      endcase
    end
  end
endmodule

// ===== design/hierarchical_page_walk_with_eviction.sv =====
`timescale 1ns / 1ps
// a hit reads one table entry per level, then does the access (a read adds a wait state)
// and loads the output register; a miss adds a depth-first scan of the tables and then
// zeroing, filling or copying of frames
// one item at a time: a new item is taken only once the previous result has been loaded
// reset is synchronous; then a clearing pass over every swap store address zeroes the swap store
// and the frame memory before the first item is accepted
// ----------------------------------------------------------------------------
// hierarchical_page_walk_with_eviction
// multi-level page table walk with frame reuse and cyclic-distance eviction
// ----------------------------------------------------------------------------
`include "hierarchical_page_walk_with_eviction_assert.svh"

module hierarchical_page_walk_with_eviction import hpwe_pkg::*; (
  input logic      clk,
  input logic      rst,
  hpwe_req_if.sink   req,
  hpwe_rsp_if.source rsp
);
  typedef enum logic [14:0] {
    S_CLR    = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_WRD    = 15'b000000000000100,
    S_WCHK   = 15'b000000000001000,
    S_SCAN   = 15'b000000000010000,
    S_UNLINK = 15'b000000000100000,
    S_CPRD   = 15'b000000001000000,
    S_CPWR   = 15'b000000010000000,
    S_FLRD   = 15'b000000100000000,
    S_FLWR   = 15'b000001000000000,
    S_LINK   = 15'b000010000000000,
    S_ACC    = 15'b000100000000000,
    S_ACCWT  = 15'b001000000000000,
    S_FIN    = 15'b010000000000000,
    S_SPARE  = 15'b100000000000000
  } state_t;

  state_t state;

  // latched item
  logic        func_r;
  logic [15:0] va_r;
  word_t       wd_r;

  // walk registers
  lvl_t       lvl;
  word_t      cur;
  word_t      nxt;
  off_t       j;
  fm_addr_t   ul_addr;
  logic [SW_AW-1:0] clr_cnt;

  // result waiting for the output register
  logic  res_ok;
  word_t res_data;

  // frame memory and swap store ports
  logic     fm_we;
  fm_addr_t fm_waddr, fm_raddr;
  word_t    fm_wdata, fm_rdata;
  logic             sw_we;
  logic [SW_AW-1:0] sw_waddr, sw_raddr;
  word_t            sw_wdata, sw_rdata;

  // scan unit
  logic      scan_start;
  logic      scan_done;
  fm_addr_t  scan_raddr;
  scan_res_t sres;

  off_t  slot;
  page_t page;
  off_t  woff;
  logic  leaf;
  logic  out_of_range;
  logic  out_free;

  assign slot         = off_t'(va_r >> (OFFSET_BITS * (TABLE_LEVELS - int'(lvl))));
  assign page         = va_r[VA_BITS-1:OFFSET_BITS];
  assign woff         = va_r[OFFSET_BITS-1:0];
  assign leaf         = (lvl == lvl_t'(TABLE_LEVELS - 1));
  assign out_of_range = |(req.virt_addr >> VA_BITS);
  assign out_free     = !rsp.valid || rsp.ready;
  assign req.ready    = (state == S_IDLE);
  assign scan_start   = (state == S_WCHK) && (fm_rdata == '0);

  hpwe_ram #(.W(WORD_BITS), .DEPTH(FM_DEPTH)) u_frame_mem (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  hpwe_ram #(.W(WORD_BITS), .DEPTH(SW_DEPTH)) u_swap_mem (
    .clk   (clk),
    .we    (sw_we),
    .waddr (sw_waddr),
    .wdata (sw_wdata),
    .raddr (sw_raddr),
    .rdata (sw_rdata)
  );

  hpwe_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .entered (cur),
    .target  (page),
    .rdata   (fm_rdata),
    .raddr   (scan_raddr),
    .done    (scan_done),
    .res     (sres)
  );

  // memory port steering by walk state
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = fm_addr(cur, slot);
    fm_wdata = nxt;
    fm_raddr = scan_raddr;
    sw_we    = 1'b0;
    sw_waddr = {sres.victim_page, j};
    sw_wdata = fm_rdata;
    sw_raddr = {page, j};
    case (state)
      S_CLR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_cnt[FM_AW-1:0];
        fm_wdata = '0;
        sw_we    = 1'b1;
        sw_waddr = clr_cnt;
        sw_wdata = '0;
      end
      S_WRD:    fm_raddr = fm_addr(cur, slot);
      S_UNLINK: begin
        fm_we    = 1'b1;
        fm_waddr = ul_addr;
        fm_wdata = '0;
      end
      S_CPRD:   fm_raddr = fm_addr(sres.victim_frame, j);
      S_CPWR:   sw_we = 1'b1;
      S_FLWR: begin
        // table frames are zeroed, leaf frames come from the swap image
        fm_we    = 1'b1;
        fm_waddr = fm_addr(nxt, j);
        fm_wdata = leaf ? sw_rdata : '0;
      end
      S_LINK:   fm_we = 1'b1;
      S_ACC: begin
        fm_raddr = fm_addr(cur, woff);
        fm_we    = func_r;
        fm_waddr = fm_addr(cur, woff);
        fm_wdata = wd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // the final state reloads the output itself when it is free
      if (rsp.valid && rsp.ready && state != S_FIN) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + SW_AW'(1);
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            func_r   <= req.func;
            va_r     <= req.virt_addr;
            wd_r     <= WORD_BITS'(req.write_data);
            lvl      <= '0;
            cur      <= '0;
            res_ok   <= 1'b0;
            res_data <= '0;
            state    <= out_of_range ? S_FIN : S_WRD;
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (fm_rdata != '0) begin
            cur <= fm_rdata;
            if (leaf) begin
              state <= S_ACC;
            end else begin
              lvl   <= lvl + lvl_t'(1);
              state <= S_WRD;
            end
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            j <= '0;
            if (sres.have_zero) begin
              // reuse an empty table frame
              nxt     <= sres.zero_frame;
              ul_addr <= {sres.zero_parent, sres.zero_slot};
              state   <= S_UNLINK;
            end else if (sres.top_frame < word_t'(FRAME_COUNT - 1)) begin
              nxt   <= sres.top_frame + word_t'(1);
              state <= leaf ? S_FLRD : S_FLWR;
            end else if (sres.have_victim) begin
              // evict: copy the page out, then unlink it
              nxt     <= sres.victim_frame;
              ul_addr <= {sres.victim_parent, sres.victim_slot};
              state   <= S_CPRD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          j <= j + off_t'(1);
          state <= (&j) ? S_UNLINK : S_CPRD;
        end
        S_UNLINK: begin
          j     <= '0;
          state <= leaf ? S_FLRD : S_FLWR;
        end
        S_FLRD: state <= S_FLWR;
        S_FLWR: begin
          j <= j + off_t'(1);
          if (&j) begin
            state <= S_LINK;
          end else begin
            state <= leaf ? S_FLRD : S_FLWR;
          end
        end
        S_LINK: begin
          cur <= nxt;
          if (leaf) begin
            state <= S_ACC;
          end else begin
            lvl   <= lvl + lvl_t'(1);
            state <= S_WRD;
          end
        end
        S_ACC: begin
          res_ok <= 1'b1;
          state  <= func_r ? S_FIN : S_ACCWT;
        end
        S_ACCWT: begin
          res_data <= fm_rdata;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid     <= 1'b1;
            rsp.ok        <= res_ok;
            rsp.read_data <= 32'(res_data);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an out-of-range item goes straight to the result stage
  `HPWE_AST_NEXT(a_oor_fin, req.valid && req.ready && out_of_range, state == S_FIN)
  // the scan unit reports only while the walk waits on it
  `HPWE_AST_NOW(a_scan_done, scan_done, state == S_SCAN)
  // a result handed over from the final state shows up on the port
  `HPWE_AST_NEXT(a_fin_load, state == S_FIN && out_free, rsp.valid)
  // a finished access is always a good result
  `HPWE_AST_NEXT(a_acc_ok, state == S_ACC, res_ok)

endmodule

// ===== dv/hpwe_walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpwe_walk_checker
// watches both channels, predicts each response from its own page table and
// swap store, and compares every response with the oldest prediction
// ----------------------------------------------------------------------------
module hpwe_walk_checker import hpwe_pkg::*; (
  input  logic clk,
  input  logic rst,
  hpwe_req_if  req,
  hpwe_rsp_if  rsp,
  output int   fails,
  output int   pending
);

  typedef longint unsigned u64_t;

  typedef struct {
    logic        ok;
    logic [31:0] data;
  } access_rsp_t;

  access_rsp_t expected_rsps[$];

  logic [WORD_BITS-1:0] frame_mem [FM_DEPTH];
  logic [WORD_BITS-1:0] swap_mem  [SW_DEPTH];

  // results of one scan over the tables
  u64_t scan_entered, scan_target, scan_max;
  bit   zero_found, victim_found;
  u64_t zero_frame, zero_parent, zero_slot;
  u64_t best_dist, victim_frame, victim_page, victim_parent, victim_slot;

  function automatic int fm_word_index(u64_t frame, u64_t off);
    return int'((frame * PAGE_WORDS + off) % u64_t'(FM_DEPTH));
  endfunction

  function automatic int swap_idx(u64_t page, u64_t off);
    return int'((page * PAGE_WORDS + off) % u64_t'(SW_DEPTH));
  endfunction

  // depth-first, ascending index; post-order for empty tables
  function automatic void scan_tables(u64_t frame, int depth, u64_t parent,
                                      u64_t slot, u64_t page);
    bit   empty;
    u64_t e, d, alt, cd;
    if (depth == TABLE_LEVELS) begin
      if (frame != scan_entered) begin
        d   = (scan_target > page) ? scan_target - page : page - scan_target;
        alt = u64_t'(PAGE_COUNT) - d;
        cd  = (alt < d) ? alt : d;
        if (cd > best_dist) begin
          best_dist     = cd;
          victim_found  = 1;
          victim_frame  = frame;
          victim_page   = page;
          victim_parent = parent;
          victim_slot   = slot;
        end
      end
      return;
    end
    empty = 1;
    for (int i = 0; i < PAGE_WORDS; i++) begin
      e = u64_t'(frame_mem[fm_word_index(frame, i)]);
      if (e != 0) begin
        empty = 0;
        if (e > scan_max) scan_max = e;
        scan_tables(e, depth + 1, frame, i, (page << OFFSET_BITS) + i);
      end
    end
    if (empty && frame != scan_entered && depth > 0) begin
      zero_found  = 1;
      zero_frame  = frame;
      zero_parent = parent;
      zero_slot   = slot;
    end
  endfunction

  // walk the tables, linking frames on misses; returns 0 when no frame is free
  function automatic bit walk_tables(u64_t va, output u64_t leaf);
    u64_t cur, pg, slot, nxt;
    int   sh;
    cur  = 0;
    pg   = va >> OFFSET_BITS;
    leaf = 0;
    for (int lvl = 0; lvl < TABLE_LEVELS; lvl++) begin
      sh   = (TABLE_LEVELS - lvl) * OFFSET_BITS;
      slot = (va >> sh) & u64_t'(PAGE_WORDS - 1);
      nxt  = u64_t'(frame_mem[fm_word_index(cur, slot)]);
      if (nxt == 0) begin
        scan_entered = cur;
        scan_target  = pg;
        scan_max     = 0;
        zero_found   = 0;
        victim_found = 0;
        best_dist    = 0;
        scan_tables(0, 0, 0, 0, 0);
        if (zero_found) begin
          nxt = zero_frame;
          frame_mem[fm_word_index(zero_parent, zero_slot)] = '0;
        end else if (scan_max < u64_t'(FRAME_COUNT - 1)) begin
          nxt = scan_max + 1;
        end else if (victim_found) begin
          for (int j = 0; j < PAGE_WORDS; j++)
            swap_mem[swap_idx(victim_page, j)] = frame_mem[fm_word_index(victim_frame, j)];
          frame_mem[fm_word_index(victim_parent, victim_slot)] = '0;
          nxt = victim_frame;
        end else begin
          return 0;
        end
        for (int j = 0; j < PAGE_WORDS; j++)
          frame_mem[fm_word_index(nxt, j)] =
            (lvl + 1 < TABLE_LEVELS) ? '0 : swap_mem[swap_idx(pg, j)];
        frame_mem[fm_word_index(cur, slot)] = nxt[WORD_BITS-1:0];
      end
      cur = nxt;
    end
    leaf = cur;
    return 1;
  endfunction

  function automatic access_rsp_t predict_access(logic f, logic [15:0] va,
                                                 logic [31:0] wd);
    access_rsp_t r;
    u64_t        leaf;
    int          idx;
    r.ok   = 0;
    r.data = '0;
    if ((u64_t'(va) >> VA_BITS) != 0) return r;
    if (!walk_tables(u64_t'(va), leaf)) return r;
    idx = fm_word_index(leaf, u64_t'(va) & u64_t'(PAGE_WORDS - 1));
    if (f) frame_mem[idx] = WORD_BITS'(signed'(wd));
    else   r.data = frame_mem[idx][31:0];
    r.ok = 1;
    return r;
  endfunction

  always @(posedge clk) begin
    access_rsp_t want;
    if (rst) begin
      for (int i = 0; i < FM_DEPTH; i++) frame_mem[i] = '0;
      for (int i = 0; i < SW_DEPTH; i++) swap_mem[i] = '0;
      expected_rsps.delete();
      fails = 0;
    end else begin
      if (req.valid && req.ready)
        expected_rsps.push_back(predict_access(req.func, req.virt_addr, req.write_data));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: response with none outstanding ok=%0b data=%h",
                     $realtime, rsp.ok, rsp.read_data);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.ok !== want.ok || rsp.read_data !== want.data) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch ok exp=%0b act=%0b data exp=%h act=%h",
                       $realtime, want.ok, rsp.ok, want.data, rsp.read_data);
          end
        end
      end
    end
    pending = expected_rsps.size();
  end

endmodule

// ===== dv/hierarchical_page_walk_with_eviction_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_page_walk_with_eviction_tb
// directed and random reads and writes through the page walker, with bursty
// requests, a stalling response side and one long response hold-off
// ----------------------------------------------------------------------------
module hierarchical_page_walk_with_eviction_tb;
  import hpwe_pkg::*;

  localparam int N_RANDOM   = 1000;
  localparam int IDLE_LIMIT = 30000;   // covers the clearing pass and the hold-off
  localparam int HOLD_LEN   = 3000;
  localparam int DRAIN_WAIT = 800;

  logic clk;
  logic rst;

  hpwe_req_if req ();
  hpwe_rsp_if rsp ();

  int fails;
  int outstanding;

  // counters for the closing summary
  int n_reads, n_writes, n_rejected;

  // long hold-off request toward the response side
  logic hold_go;

  // burst state of the request side
  int burst_left;

  hierarchical_page_walk_with_eviction DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  hpwe_walk_checker walk_chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .fails   (fails),
    .pending (outstanding)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // offer one item and hold it until it is taken; valid stays high afterwards
  // so back-to-back items inside a burst need no extra assignment
  task automatic send_access(input logic f, input logic [15:0] va,
                             input logic [31:0] wd);
    int gap;
    if (burst_left == 0) begin
      // end of a burst: drop valid for a random gap, sometimes none at all
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req.valid      <= 1'b1;
    req.func       <= f;
    req.virt_addr  <= va;
    req.write_data <= wd;
    if (f) n_writes++;
    else   n_reads++;
    if (va >= 16'(1 << VA_BITS)) n_rejected++;
    do @(posedge clk); while (!(req.valid && req.ready));
  endtask

  // response side: its own stall pattern, plus one long hold-off on request
  initial begin : rsp_side
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && hold_left == 0 && phase >= 0) begin
        hold_left = HOLD_LEN;
        phase     = -1;          // only once
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        // alternate stretches of always-ready and random stalling
        phase = (phase < 0) ? phase - 1 : phase + 1;
        if (((phase < 0 ? -phase : phase) / 200) % 2 == 0)
          rsp.ready <= 1'b1;
        else
          rsp.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] va;
    logic [15:0] hot_pages [8];
    int          pick;

    rst            = 1'b1;
    req.valid      = 1'b0;
    req.func       = 1'b0;
    req.virt_addr  = '0;
    req.write_data = '0;
    hold_go        = 1'b0;
    burst_left     = 0;
    n_reads        = 0;
    n_writes       = 0;
    n_rejected     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of the address and data, out-of-range addresses
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b1, 16'h0FFF, 32'h7FFF_FFFF);
    send_access(1'b0, 16'h0FFF, 32'hFFFF_FFFF);
    send_access(1'b1, 16'h0000, 32'h8000_0000);
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b1, 16'h1000, 32'h1234_5678);
    send_access(1'b0, 16'hFFFF, 32'h0);
    send_access(1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    // fill frames across many pages so eviction and empty tables show up
    for (int i = 0; i < 14; i++)
      send_access(1'b1, 16'((i * 37 % 16) << 8 | (i << 4) | i), 32'hA5A5_0000 + i);
    // page 0 came back from swap after being evicted
    send_access(1'b0, 16'h0000, 32'h0);
    send_access(1'b0, 16'h0FFF, 32'h0);

    for (int i = 0; i < 8; i++) hot_pages[i] = 16'($urandom_range(0, PAGE_COUNT - 1));

    // random: mostly a small working set to mix hits with evictions, some
    // scattered pages, a few out-of-range addresses
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) hold_go <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        va = {hot_pages[$urandom_range(0, 7)][11:0], 4'($urandom_range(0, 15))} & 16'h0FFF;
      else if (pick < 92)
        va = 16'($urandom_range(0, (1 << VA_BITS) - 1));
      else
        va = 16'($urandom_range(1 << VA_BITS, 16'hFFFF));
      if (pick < 55) va = {4'h0, hot_pages[$urandom_range(0, 7)][7:0], va[3:0]};
      send_access(1'($urandom_range(0, 1)), va, 32'($urandom));
    end
    req.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d reads and %0d writes, %0d of them out of range", n_reads,
             n_writes, n_rejected);
    $display("working-set and scattered pages drove frame reuse and eviction");
    if (fails == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
